// ===== hdl/ppbp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppbp_pkg
// shared constants, types and helper functions for the path perceptron branch predictor
// ----------------------------------------------------------------------------
package ppbp_pkg;

  localparam int TableRowsDefault     = 128;
  localparam int HistoryLengthDefault = 15;
  localparam int WeightW              = 8;
  localparam int PsumW                = 13;
  localparam int SumW                 = 12;
  localparam int ThrW                 = 12;
  localparam logic [ThrW-1:0] ThrReset = 12'd7;

  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_TRAIN   = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRED_RD,
    ST_TRAIN_RD,
    ST_TRAIN_WR
  } state_t;

  function automatic logic signed [PsumW-1:0] sat13(input logic signed [PsumW+1:0] x);
    logic signed [PsumW-1:0] r;
    if (x > 15'sd4095) r = 13'sd4095;
    else if (x < -15'sd4096) r = -13'sd4096;
    else r = x[PsumW-1:0];
    return r;
  endfunction

  function automatic logic signed [WeightW-1:0] bump(input logic signed [WeightW-1:0] w,
                                                     input logic up);
    logic signed [WeightW-1:0] r;
    r = w;
    if (up) begin
      if (w != 8'sd127) r = w + 8'sd1;
    end else begin
      if (w != -8'sd128) r = w - 8'sd1;
    end
    return r;
  endfunction

endpackage

// ===== hdl/path_perceptron_branch_predictor_unit.sv =====
// ----------------------------------------------------------------------------
// path_perceptron_branch_predictor_unit
// path based perceptron branch predictor, weight rows kept in one memory
// ----------------------------------------------------------------------------
// A predict reads the weight row while idle, then in ST_PRED_RD forms the sum
// and folds the row into the speculative partial sums; the result strobes on
// the cycle after. A train reads the row of the last prediction and the
// diagonal of weights along the recorded path (one read per history position,
// each from its own column bank) and then, in ST_TRAIN_WR, writes them back
// when do_train is set. The weight memory is one row wide, split into
// HISTORY_LENGTH+1 column banks of TABLE_ROWS words. After reset the unit
// clears the weight memory one row a cycle through all TABLE_ROWS rows, with
// busy high. Results cannot be held off; threshold writes are taken at any time.
module path_perceptron_branch_predictor_unit
  import ppbp_pkg::*;
#(
  parameter int TABLE_ROWS     = TableRowsDefault,
  parameter int HISTORY_LENGTH = HistoryLengthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  opcode,
  input  logic [31:0]           branch_address,
  input  logic                  outcome_taken,
  output logic                  result_valid,
  output logic                  prediction_taken,
  output logic signed [SumW-1:0] perceptron_sum,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ThrW-1:0]       cfg_data
);

  localparam int RowW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int Hl1  = HISTORY_LENGTH + 1;

  typedef logic [RowW-1:0] row_t;
  typedef logic signed [PsumW-1:0] psum_t;
  typedef logic signed [WeightW-1:0] wt_t;

  // weight memory: one bank per column
  wt_t   wmem [Hl1][TABLE_ROWS];
  row_t  rd_addr [Hl1];
  wt_t   rd_data [Hl1];
  logic  wr_en;
  row_t  wr_addr [Hl1];
  wt_t   wr_data [Hl1];

  // the fold of the committed sums needs the whole last row, read in a
  // second bank set that always addresses last_row
  wt_t   cm_mem [Hl1][TABLE_ROWS];
  wt_t   cm_data [Hl1];

  state_t state, state_next;
  row_t   clr_row;
  logic [ThrW-1:0] thr;

  psum_t spec_ps [Hl1];
  psum_t comm_ps [Hl1];
  logic  spec_hist [Hl1];
  logic  comm_hist [Hl1];
  row_t  spec_path [Hl1];
  row_t  comm_path [Hl1];
  row_t  last_path [Hl1];
  logic  last_hist [Hl1];
  psum_t last_sum;
  row_t  last_row;
  logic  last_pred;

  row_t  cur_row;
  logic  cur_outcome;
  logic  do_train;
  psum_t y;
  logic  pred;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) thr <= ThrReset;
    else if (cfg_valid && cfg_ready) thr <= cfg_data;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_row == row_t'(TABLE_ROWS - 1)) state_next = ST_IDLE;
      ST_IDLE:     if (start) state_next = (opcode == OP_TRAIN) ? ST_TRAIN_RD : ST_PRED_RD;
      ST_PRED_RD:  state_next = ST_IDLE;
      ST_TRAIN_RD: state_next = ST_TRAIN_WR;
      ST_TRAIN_WR: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_row <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_row <= clr_row + row_t'(1);
    end
  end

  // read addresses: a new predict reads one row, otherwise read along the path
  always_comb begin
    for (int j = 0; j < Hl1; j++) begin
      if (state == ST_IDLE && opcode == OP_PREDICT)
        rd_addr[j] = row_t'(branch_address % TABLE_ROWS);
      else
        rd_addr[j] = (j == 0) ? last_row : last_path[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < Hl1; j++) begin
      if (wr_en) wmem[j][wr_addr[j]] <= wr_data[j];
      rd_data[j] <= wmem[j][rd_addr[j]];
    end
  end

  always_comb begin
    do_train = (last_pred != cur_outcome) ||
               ($signed({1'b0, thr}) > 14'(last_sum) && 14'(last_sum) > -$signed({1'b0, thr}));
    wr_en = (state == ST_CLEAR) || (state == ST_TRAIN_WR && do_train);
    for (int j = 0; j < Hl1; j++) begin
      if (state == ST_CLEAR) begin
        wr_addr[j] = clr_row;
        wr_data[j] = '0;
      end else begin
        wr_addr[j] = (j == 0) ? last_row : last_path[j];
        wr_data[j] = bump(rd_data[j], (j == 0) ? cur_outcome : (cur_outcome == last_hist[j]));
      end
    end
    y    = sat13(15'(spec_ps[HISTORY_LENGTH]) + 15'(rd_data[0]));
    pred = !y[PsumW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      last_sum     <= '0;
      last_row     <= '0;
      last_pred    <= 1'b0;
      for (int j = 0; j < Hl1; j++) begin
        spec_ps[j] <= '0; comm_ps[j] <= '0;
        spec_hist[j] <= 1'b0; comm_hist[j] <= 1'b0;
        spec_path[j] <= '0; comm_path[j] <= '0;
        last_path[j] <= '0; last_hist[j] <= 1'b0;
      end
    end else begin
      result_valid <= 1'b0;
      if (state == ST_IDLE && start) begin
        cur_row     <= row_t'(branch_address % TABLE_ROWS);
        cur_outcome <= outcome_taken;
      end
      if (state == ST_PRED_RD) begin
        for (int j = 1; j < Hl1; j++) begin
          spec_path[j] <= spec_path[j-1];
          last_path[j] <= spec_path[j-1];
          last_hist[j] <= spec_hist[j];
          spec_hist[j] <= spec_hist[j-1];
          spec_ps[HISTORY_LENGTH-j+1] <= sat13(pred
                                 ? 15'(spec_ps[HISTORY_LENGTH-j]) + 15'(rd_data[j])
                                 : 15'(spec_ps[HISTORY_LENGTH-j]) - 15'(rd_data[j]));
        end
        spec_path[0] <= cur_row;
        last_path[0] <= cur_row;
        last_hist[0] <= spec_hist[0];
        spec_hist[0] <= pred;
        spec_ps[0]   <= '0;
        last_sum     <= y;
        last_row     <= cur_row;
        last_pred    <= pred;
        result_valid <= 1'b1;
        prediction_taken <= pred;
        if (y > 13'sd2047)       perceptron_sum <= 12'sd2047;
        else if (y < -13'sd2048) perceptron_sum <= -12'sd2048;
        else                     perceptron_sum <= y[SumW-1:0];
      end
      if (state == ST_TRAIN_WR) begin
        for (int j = 1; j < Hl1; j++) begin
          comm_ps[HISTORY_LENGTH-j+1] <= sat13(cur_outcome
                              ? 15'(comm_ps[HISTORY_LENGTH-j]) + 15'(cm_data[j])
                              : 15'(comm_ps[HISTORY_LENGTH-j]) - 15'(cm_data[j]));
          comm_hist[j] <= comm_hist[j-1];
          comm_path[j] <= comm_path[j-1];
        end
        comm_ps[0]   <= '0;
        comm_hist[0] <= cur_outcome;
        comm_path[0] <= last_row;
        if (last_pred != cur_outcome) begin
          for (int j = 1; j < Hl1; j++) begin
            spec_ps[HISTORY_LENGTH-j+1] <= sat13(cur_outcome
                                ? 15'(comm_ps[HISTORY_LENGTH-j]) + 15'(cm_data[j])
                                : 15'(comm_ps[HISTORY_LENGTH-j]) - 15'(cm_data[j]));
            spec_hist[j] <= comm_hist[j-1];
            spec_path[j] <= comm_path[j-1];
          end
          spec_ps[0]   <= '0;
          spec_hist[0] <= cur_outcome;
          spec_path[0] <= last_row;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < Hl1; j++) begin
      if (wr_en) cm_mem[j][wr_addr[j]] <= wr_data[j];
      cm_data[j] <= cm_mem[j][last_row];
    end
  end

  property p_no_result_on_train;
    @(posedge clk) disable iff (rst) (state == ST_TRAIN_WR) |=> !result_valid;
  endproperty
  assert property (p_no_result_on_train) else $error("result on train");

  property p_result_after_predict;
    @(posedge clk) disable iff (rst) (state == ST_PRED_RD) |=> result_valid;
  endproperty
  assert property (p_result_after_predict) else $error("missing result");

  property p_busy_while_clear;
    @(posedge clk) disable iff (rst) (state == ST_CLEAR) |-> busy;
  endproperty
  assert property (p_busy_while_clear) else $error("idle during clear");

endmodule
